FILE: rtl/hrkf_pkg.sv
// Shared types and constants for the HID report key filter.
`timescale 1ns / 1ps
package hrkf_pkg;

  localparam int unsigned NUM_SLOTS = 6;

  localparam logic [7:0]  KEY_ESCAPE         = 8'h29;
  localparam logic [7:0]  KEY_PAUSE          = 8'h48;
  localparam logic [15:0] LONG_PRESS_DEFAULT = 16'd2000;
  localparam logic [15:0] ELAPSED_MAX        = 16'hFFFF;

  typedef logic [7:0] key_t;
  typedef key_t [NUM_SLOTS-1:0] key_vec_t;

  // Item kind carried on the input tuser
  typedef enum logic {
    OP_REPORT = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  // Summary of one report's key slots
  typedef struct packed {
    logic esc_in;
    logic pause_in;
    logic any_key;
  } scan_t;

  // One result item
  typedef struct packed {
    key_vec_t   keys;
    logic [7:0] reserved_byte;
    logic [7:0] modifier_bits;
    logic       exit_request;
    logic       start_sending;
    logic       stop_sending;
    logic       last_of_run;
  } result_t;

endpackage

FILE: rtl/hid_report_key_filter_core.sv
// Top level: HID report filter with escape long-press exit request.
// Path: input register, then output register for each result item.
// Throughput: one item per cycle unless the output stalls; a short escape release is held
// in the input register until both its result items are loaded into the single output register.
// Reset: synchronous, active low; clears escape/pause/exit state and the pipeline valids,
// and sets long_press_ms back to 2000.
`timescale 1ns / 1ps
module hid_report_key_filter_core #(
  parameter int KEY_SLOTS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // modifier_bits, reserved_byte, key_slot_0 .. key_slot_5
  input  logic [1:0]  in_tuser,   // operation, link_up
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // out_modifier_bits, out_reserved_byte, out_key_0 .. out_key_5
  output logic [2:0]  out_tuser,  // stop_sending, start_sending, exit_request
  output logic        out_tlast,  // last_of_run
  // Configuration: long_press_ms
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import hrkf_pkg::*;

  // Input register
  logic        in_valid_r;
  logic [63:0] in_data_r;
  logic [1:0]  in_user_r;

  // Block state
  logic [15:0] long_press_r;
  logic        esc_held_r,  esc_held_nxt;
  logic [15:0] esc_elapsed_r, esc_elapsed_nxt;
  logic        pause_held_r, pause_held_nxt;
  logic        exit_done_r, exit_done_nxt;
  logic        phase_r;

  // Output register
  logic        out_valid_r;
  result_t     out_r;

  key_vec_t    keys, esc_keys;
  scan_t       scan;
  op_t         op;
  logic        link_up;
  logic [7:0]  mod_bits, rsv_byte;
  logic [15:0] elapsed_inc;
  logic        short_esc, start, stop, emit_exit;
  logic [1:0]  n_res;
  result_t     res;
  logic        can_out, advance, pop, load;

  hrkf_filter #(.KEY_SLOTS(KEY_SLOTS)) u_filter (
    .slots    (in_data_r[63:16]),
    .keys     (keys),
    .esc_keys (esc_keys),
    .scan     (scan)
  );

  assign op       = op_t'(in_user_r[0]);
  assign link_up  = in_user_r[1];
  assign mod_bits = in_data_r[7:0];
  assign rsv_byte = in_data_r[15:8];
  assign elapsed_inc = (esc_elapsed_r == ELAPSED_MAX) ? esc_elapsed_r
                                                     : esc_elapsed_r + 16'd1;

  // Item decode: result count and next state
  always_comb begin
    esc_held_nxt    = esc_held_r;
    esc_elapsed_nxt = esc_elapsed_r;
    pause_held_nxt  = pause_held_r;
    exit_done_nxt   = exit_done_r;
    short_esc       = 1'b0;
    start           = 1'b0;
    emit_exit       = 1'b0;
    n_res           = 2'd0;
    if (!exit_done_r) begin
      unique case (op)
        OP_TICK: begin
          if (esc_held_r) begin
            esc_elapsed_nxt = elapsed_inc;
            if (elapsed_inc >= long_press_r) begin
              emit_exit = 1'b1;
            end
          end
        end
        OP_REPORT: begin
          if (scan.esc_in && !esc_held_r) begin
            esc_held_nxt    = 1'b1;
            esc_elapsed_nxt = '0;
          end
          if (!scan.esc_in && esc_held_r) begin
            esc_held_nxt = 1'b0;
            if (esc_elapsed_r >= long_press_r) begin
              emit_exit = 1'b1;
            end else begin
              short_esc = 1'b1;
            end
          end
          if (!emit_exit) begin
            start          = scan.pause_in && !pause_held_r;
            pause_held_nxt = scan.pause_in;
            if (link_up) begin
              n_res = short_esc ? 2'd2 : 2'd1;
            end
          end
        end
        default: ;
      endcase
      if (emit_exit) begin
        exit_done_nxt = 1'b1;
        n_res         = 2'd1;
      end
    end
  end

  assign stop = (scan.any_key || (mod_bits != '0) || short_esc) && !start;

  // Result item for the current phase
  always_comb begin
    res = '0;
    if (emit_exit) begin
      res.exit_request = 1'b1;
      res.last_of_run  = 1'b1;
    end else begin
      res.modifier_bits = mod_bits;
      res.reserved_byte = rsv_byte;
      res.stop_sending  = stop;
      res.start_sending = start;
      if (n_res == 2'd2 && !phase_r) begin
        res.keys        = esc_keys;
        res.last_of_run = 1'b0;
      end else begin
        res.keys        = keys;
        res.last_of_run = 1'b1;
      end
    end
  end

  // Flow control
  assign can_out   = !out_valid_r || out_tready;
  assign advance   = in_valid_r && ((n_res == 2'd0) || can_out);
  assign pop       = advance && !((n_res == 2'd2) && !phase_r);
  assign load      = advance && (n_res != 2'd0);
  assign in_tready = !in_valid_r || pop;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_user_r <= in_tuser;
    end
  end

  // State, committed when the item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r  <= LONG_PRESS_DEFAULT;
      esc_held_r    <= 1'b0;
      esc_elapsed_r <= '0;
      pause_held_r  <= 1'b0;
      exit_done_r   <= 1'b0;
      phase_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        long_press_r <= cfg_data;
      end
      if (pop) begin
        esc_held_r    <= esc_held_nxt;
        esc_elapsed_r <= esc_elapsed_nxt;
        pause_held_r  <= pause_held_nxt;
        exit_done_r   <= exit_done_nxt;
        phase_r       <= 1'b0;
      end else if (advance) begin
        phase_r <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (can_out) begin
      out_valid_r <= load;
    end
    if (load) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.keys, out_r.reserved_byte, out_r.modifier_bits};
  assign out_tuser  = {out_r.exit_request, out_r.start_sending, out_r.stop_sending};
  assign out_tlast  = out_r.last_of_run;

`ifndef ASSERT_OFF
  // Second half of a pair only while its item is still held
  a_phase_item: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> in_valid_r)
    else $error("phase set without an item in the input register");

  // First half of a pair is still in or just left through the output register
  a_phase_out: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> out_valid_r)
    else $error("phase set with empty output register");

  // Exit is sticky
  a_exit_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    exit_done_r |=> exit_done_r)
    else $error("exit state cleared");

  // Emitting the exit request locks the block
  a_exit_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res.exit_request) |=> exit_done_r)
    else $error("exit request without exit state");

  // Silent after exit
  a_silent: assert property (@(posedge clk) disable iff (!rst_n)
    exit_done_r |-> !load)
    else $error("result produced after exit");
`endif

endmodule

FILE: rtl/hrkf_filter.sv
// Key slot scan: drops escape and pause, packs the other keys to the front.
`timescale 1ns / 1ps
module hrkf_filter #(
  parameter int KEY_SLOTS = 6
) (
  input  hrkf_pkg::key_vec_t slots,
  output hrkf_pkg::key_vec_t keys,
  output hrkf_pkg::key_vec_t esc_keys,
  output hrkf_pkg::scan_t    scan
);
  import hrkf_pkg::*;

  logic [2:0] cnt;

  // Pack nonzero, non-special codes in slot order
  always_comb begin
    keys         = '0;
    cnt          = '0;
    scan.esc_in   = 1'b0;
    scan.pause_in = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (i < KEY_SLOTS) begin
        if (slots[i] == KEY_ESCAPE) begin
          scan.esc_in = 1'b1;
        end else if (slots[i] == KEY_PAUSE) begin
          scan.pause_in = 1'b1;
        end else if (slots[i] != '0) begin
          keys[cnt] = slots[i];
          cnt       = cnt + 3'd1;
        end
      end
    end
    scan.any_key = (cnt != 3'd0);
  end

  // Escape goes into the first empty slot, which is right after the packed keys
  always_comb begin
    esc_keys = keys;
    if (32'(cnt) < KEY_SLOTS) begin
      esc_keys[cnt] = KEY_ESCAPE;
    end
  end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the HID report key filter: stream stimulus, prediction, checks.
`timescale 1ns / 1ps
module tb_top;
  import hrkf_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 300;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned END_CYCLES      = 10;
  localparam int unsigned IDLE_LIMIT      = 2000;

  // Escape/pause tracker and expected result store
  class key_filter_scoreboard;
    logic [15:0] long_press_ms;
    bit          esc_held;
    logic [15:0] esc_elapsed;
    bit          pause_held;
    bit          exit_done;
    result_t     expected_results[$];
    int unsigned errors;
    int unsigned items_noted;
    int unsigned results_checked;
    int unsigned short_escapes;
    int unsigned pause_starts;

    function new();
      long_press_ms = LONG_PRESS_DEFAULT;
      esc_held      = 1'b0;
      esc_elapsed   = '0;
      pause_held    = 1'b0;
      exit_done     = 1'b0;
    endfunction

    function void push_exit();
      result_t r;
      r              = '0;
      r.exit_request = 1'b1;
      r.last_of_run  = 1'b1;
      exit_done      = 1'b1;
      expected_results.push_back(r);
    endfunction

    // Update the key state for one accepted item and queue what it should produce
    function void note_item(op_t op, logic link, key_t mod, key_t rsv, key_vec_t slots);
      key_vec_t    kept;
      key_vec_t    with_esc;
      int unsigned n;
      bit          esc_in, pause_in, short_esc, start, stop, placed;
      result_t     r;
      items_noted++;
      if (exit_done) return;

      if (op == OP_TICK) begin
        if (!esc_held) return;
        if (esc_elapsed != ELAPSED_MAX) esc_elapsed++;
        if (esc_elapsed >= long_press_ms) push_exit();
        return;
      end

      // strip escape and pause, pack the rest to the front
      kept      = '0;
      n         = 0;
      esc_in    = 1'b0;
      pause_in  = 1'b0;
      short_esc = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slots[i] == KEY_ESCAPE) esc_in = 1'b1;
        else if (slots[i] == KEY_PAUSE) pause_in = 1'b1;
        else if (slots[i] != 8'h00) begin
          kept[n] = slots[i];
          n++;
        end
      end

      if (esc_in && !esc_held) begin
        esc_held    = 1'b1;
        esc_elapsed = '0;
      end
      if (!esc_in && esc_held) begin
        esc_held = 1'b0;
        if (esc_elapsed >= long_press_ms) begin
          push_exit();
          return;
        end
        short_esc = 1'b1;
      end

      start      = pause_in && !pause_held;
      pause_held = pause_in;
      if (!link) return;

      stop            = (n > 0 || mod != 8'h00 || short_esc) && !start;
      r.modifier_bits = mod;
      r.reserved_byte = rsv;
      r.exit_request  = 1'b0;
      r.start_sending = start;
      r.stop_sending  = stop;
      if (start) pause_starts++;

      // short escape: escape goes into the first empty slot, then the plain report
      if (short_esc) begin
        with_esc = kept;
        placed   = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!placed && with_esc[i] == 8'h00) begin
            with_esc[i] = KEY_ESCAPE;
            placed      = 1'b1;
          end
        end
        r.keys        = with_esc;
        r.last_of_run = 1'b0;
        expected_results.push_back(r);
        short_escapes++;
      end
      r.keys        = kept;
      r.last_of_run = 1'b1;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [63:0] tdata, logic [2:0] tuser, logic tlast);
      result_t want;
      results_checked++;
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected: tdata %h tuser %b tlast %b",
               tdata, tuser, tlast);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("out_modifier_bits", want.modifier_bits, tdata[7:0]);
      compare_field("out_reserved_byte", want.reserved_byte, tdata[15:8]);
      for (int i = 0; i < NUM_SLOTS; i++)
        compare_field($sformatf("out_key_%0d", i), want.keys[i], tdata[16+8*i +: 8]);
      compare_field("stop_sending", want.stop_sending, tuser[0]);
      compare_field("start_sending", want.start_sending, tuser[1]);
      compare_field("exit_request", want.exit_request, tuser[2]);
      compare_field("last_of_run", want.last_of_run, tlast);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  key_filter_scoreboard sb;
  bit          steady = 1'b0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned thresholds_used = 0;

  hid_report_key_filter_core #(.KEY_SLOTS(NUM_SLOTS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side back-pressure: mostly ready, short and occasional long stalls
  always @(posedge clk) begin : ready_gen
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (steady || roll < 70) begin
      out_tready <= 1'b1;
    end else if (roll < 95) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(4, 24);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("tb_top failed");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic key_vec_t slots6(key_t k0, key_t k1, key_t k2, key_t k3, key_t k4,
                                      key_t k5);
    return {k5, k4, k3, k2, k1, k0};
  endfunction

  // Present one item and hold it until accepted; valid stays high afterwards
  task automatic send_item(op_t op, logic link, key_t mod, key_t rsv, key_vec_t slots);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {slots, rsv, mod};
    in_tuser  <= {link, op};
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, link, mod, rsv, slots);
  endtask

  task automatic send_report(logic link, key_t mod, key_t rsv, key_vec_t slots);
    send_item(OP_REPORT, link, mod, rsv, slots);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 1'($urandom_range(0, 1)), key_t'($urandom_range(0, 255)),
              key_t'($urandom_range(0, 255)), key_vec_t'({$urandom(), $urandom()}));
  endtask

  // Random report or tick; ticks never carry a held escape up to the threshold
  task automatic send_random_item();
    op_t         op;
    logic        link;
    key_t        mod, rsv;
    key_vec_t    slots;
    int unsigned roll;
    bit          at_limit;
    roll     = $urandom_range(0, 99);
    op       = (roll < (sb.esc_held ? 40 : 12)) ? OP_TICK : OP_REPORT;
    at_limit = sb.esc_held &&
               ({16'd0, sb.esc_elapsed} + 32'd1 >= {16'd0, sb.long_press_ms});
    if (op == OP_TICK && at_limit) op = OP_REPORT;
    link = ($urandom_range(0, 99) < 85);
    mod  = ($urandom_range(0, 2) == 0) ? 8'h00 : key_t'($urandom_range(0, 255));
    rsv  = key_t'($urandom_range(0, 255));
    for (int i = 0; i < NUM_SLOTS; i++)
      slots[i] = ($urandom_range(0, 99) < 30) ? 8'h00 : key_t'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < (sb.esc_held ? 65 : 20))
      slots[3'($urandom_range(0, NUM_SLOTS - 1))] = KEY_ESCAPE;
    if ($urandom_range(0, 99) < (sb.pause_held ? 40 : 15))
      slots[3'($urandom_range(0, NUM_SLOTS - 1))] = KEY_PAUSE;
    send_item(op, link, mod, rsv, slots);
  endtask

  // Drop valid, let every expected result arrive, then wait so that silent items drain
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_long_press(logic [15:0] ms);
    cfg_valid <= 1'b1;
    cfg_data  <= ms;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.long_press_ms = ms;
    thresholds_used++;
  endtask

  initial begin
    logic [15:0] phase_ms [NUM_PHASES];
    int unsigned hold_ticks;
    string       exit_path;
    sb = new();
    phase_ms[0] = 16'd1;
    phase_ms[1] = 16'hFFFF;
    phase_ms[2] = 16'($urandom_range(2, 12));
    phase_ms[3] = 16'($urandom_range(1, 65535));
    phase_ms[4] = 16'($urandom_range(2, 6));
    phase_ms[5] = LONG_PRESS_DEFAULT;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, packing, pause edges, escape handling, link down
    send_report(1, 8'h00, 8'h00, slots6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(1, 8'hFF, 8'hFF, slots6(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_report(1, 8'h01, 8'h00, slots6(8'h00, 8'h04, 8'h00, 8'h05, 8'h00, 8'h06));
    send_report(1, 8'h00, 8'h5A, slots6(KEY_PAUSE, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(1, 8'h00, 8'h00, slots6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, KEY_PAUSE));
    send_report(1, 8'h00, 8'h00, slots6(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_tick();
    send_report(1, 8'h02, 8'h00, slots6(KEY_ESCAPE, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00));
    send_tick();
    send_tick();
    send_report(1, 8'h00, 8'h00, slots6(8'h00, 8'h00, 8'h06, 8'h00, 8'h00, 8'h00));
    // release with every slot taken: both results carry the same keys
    send_report(1, 8'h00, 8'h00, slots6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, KEY_ESCAPE));
    send_report(1, 8'h00, 8'h00, slots6(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    // link down: state moves, nothing is emitted
    send_report(0, 8'h10, 8'h00, slots6(KEY_ESCAPE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(0, 8'h00, 8'h00, slots6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // short escape release on the same report as a pause edge
    send_report(1, 8'h00, 8'h00, slots6(8'h00, 8'h00, 8'h00, 8'h00, KEY_ESCAPE, 8'h00));
    send_report(1, 8'h00, 8'h00, slots6(8'h00, KEY_PAUSE, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(1, 8'h00, 8'h00, slots6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // pause pressed while link down gives no start once link returns
    send_report(0, 8'h00, 8'h00, slots6(KEY_PAUSE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(1, 8'h00, 8'h00, slots6(KEY_PAUSE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(1, 8'h80, 8'h00, slots6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(1, 8'h00, 8'h01, slots6(KEY_ESCAPE, KEY_ESCAPE, KEY_PAUSE, 8'h2A, 8'h00, 8'h00));
    send_report(1, 8'h00, 8'h00, slots6(8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    settle();

    // Random phases, one threshold each; escape is always released before the next write
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_long_press(phase_ms[p]);
      steady = (p % 3 == 1);
      repeat (ITEMS_PER_PHASE) send_random_item();
      if (sb.esc_held)
        send_report(1'($urandom_range(0, 1)), 8'h00, 8'h00,
                    slots6(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      steady = 1'b0;
      settle();
    end

    // The one exit request of the run, reached by one of four routes
    case ($urandom_range(0, 3))
      0: begin
        exit_path = "zero-threshold release";
        write_long_press(16'd0);
        send_report(1, 8'h00, 8'h00, slots6(KEY_ESCAPE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(1'($urandom_range(0, 1)), 8'h00, 8'h00,
                    slots6(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      end
      1: begin
        exit_path = "one-tick hold";
        write_long_press(16'd1);
        send_report(1, 8'h00, 8'h00, slots6(KEY_ESCAPE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        steady = 1'b1;
        while (!sb.exit_done) send_tick();
        steady = 1'b0;
      end
      2: begin
        exit_path = "tick at threshold";
        write_long_press(16'($urandom_range(1, 40)));
        send_report(1, 8'h00, 8'h00, slots6(KEY_ESCAPE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        while (!sb.exit_done) send_tick();
      end
      default: begin
        exit_path = "release after threshold lowered";
        hold_ticks = $urandom_range(1, 30);
        send_report(1, 8'h00, 8'h00, slots6(KEY_ESCAPE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        repeat (hold_ticks) send_tick();
        settle();
        write_long_press(16'($urandom_range(1, hold_ticks)));
        send_report(1'($urandom_range(0, 1)), 8'h00, 8'h00,
                    slots6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      end
    endcase
    // everything after the exit must stay silent
    repeat (20) send_random_item();

    settle();
    repeat (END_CYCLES) @(posedge clk);
    if (sb.expected_results.size() != 0) begin
      $error("%0d expected result items never arrived", sb.expected_results.size());
      sb.errors++;
    end
    $display("Run: %0d items under %0d threshold writes, %0d results checked, %0d errors.",
             sb.items_noted, thresholds_used, sb.results_checked, sb.errors);
    $display("Saw %0d short escape releases and %0d pause starts; exit via %s.",
             sb.short_escapes, sb.pause_starts, exit_path);
    if (sb.errors == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
